/* hw/rtl/flash_access_command_splitter_assert.svh */
// Assertion macros shared by the flash access command splitter RTL.
`ifndef FLASH_ACCESS_COMMAND_SPLITTER_ASSERT_SVH
`define FLASH_ACCESS_COMMAND_SPLITTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FACS_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("facs assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FACS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("facs assertion failed");

`endif

/* hw/rtl/facs_pkg.sv */
// Package with types, constants and codes of the flash access command splitter.
`default_nettype none

package facs_pkg;

   // Field widths.
   localparam int ADDR_W   = 27;
   localparam int LEN_W    = 13;
   localparam int OFF_W    = 12;
   localparam int OPC_W    = 16;
   localparam int DUMMY_W  = 5;
   localparam int MODE_W   = 2;
   localparam int DEV_W    = 28;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 28;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 80;

   // Parameter defaults and limits.
   localparam int PAGE_SIZE_DEF   = 256;
   localparam int MAX_REQUEST_DEF = 4096;
   localparam int MAX_RESULTS     = 20;
   localparam int CNT_W           = $clog2(MAX_RESULTS);

   // Opcodes and dummy cycle counts.
   localparam logic [OPC_W-1:0]   OPC_PROG_SINGLE = 16'h0012;
   localparam logic [OPC_W-1:0]   OPC_PROG_OCTAL  = 16'h12ED;
   localparam logic [OPC_W-1:0]   OPC_READ_SINGLE = 16'h000C;
   localparam logic [DUMMY_W-1:0] DUMMY_READ_SINGLE = 5'd8;
   localparam logic [DUMMY_W-1:0] DUMMY_PROG = 5'd0;

   // Register reset values.
   localparam logic [OPC_W-1:0]   OCTAL_READ_OPC_RST   = 16'hEE11;
   localparam logic [DUMMY_W-1:0] OCTAL_READ_DUMMY_RST = 5'd20;
   localparam logic [DEV_W-1:0]   DEVICE_BYTES_RST     = 28'h8000000;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAL_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAL_RD_OPC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAL_RD_DUM = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_BYTES = 2'd3;

   // Pair modes of a command.
   localparam logic [MODE_W-1:0] PAIR_NONE   = 2'd0;
   localparam logic [MODE_W-1:0] PAIR_SECOND = 2'd1;
   localparam logic [MODE_W-1:0] PAIR_FIRST  = 2'd2;

   // Operation codes.
   localparam logic OP_PROGRAM = 1'b0;
   localparam logic OP_READ    = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLIP,
      ST_RUN
   } facs_state_type;

   // One command as produced by the step unit.
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      logic [MODE_W-1:0] mode;
      logic [LEN_W-1:0]  used;
   } facs_cmd_type;

endpackage

`default_nettype wire

/* hw/rtl/flash_access_command_splitter.sv */
// Top level of the flash access command splitter: registers, sequencer and output stage.
//
//   Channel  Direction  Handshake            Contents
//   req_*    in         tvalid/tready        tdata: address, length; tuser: operation
//   rsp_*    out        tvalid/tready        tdata: command fields; tuser: is_read; tlast
//   csr_*    in         we (no wait)         index, wdata
//
// An accepted request passes through length clipping, then the step unit forms one
// command per cycle while the output register can take it (at most 19 commands per
// request at the default page size); an empty or dropped request returns to idle from clipping.
// A low rsp_tready holds the single output register and the step unit waits.
// req_tready is high only between requests.
// Reset is synchronous and active high; it clears the sequencer, the output valid
// and loads the register defaults.
`default_nettype none

`include "flash_access_command_splitter_assert.svh"

module flash_access_command_splitter #(
   parameter int PAGE_SIZE   = facs_pkg::PAGE_SIZE_DEF,
   parameter int MAX_REQUEST = facs_pkg::MAX_REQUEST_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [26:0] request_address, [39:27] request_length
   input  wire logic [facs_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  wire logic                            req_tuser,
   // Command channel.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [15:0] cmd_opcode, [20:16] cmd_dummy, [47:21] cmd_address, [60:48] cmd_length,
   // [72:61] data_offset, [74:73] pair_mode, [79:75] zero
   output logic [facs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] cmd_is_read
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   // Configuration write port.
   input  wire logic                            csr_we,
   input  wire logic [facs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [facs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W  = facs_pkg::ADDR_W;
   localparam int LEN_W   = facs_pkg::LEN_W;
   localparam int OFF_W   = facs_pkg::OFF_W;
   localparam int OPC_W   = facs_pkg::OPC_W;
   localparam int DUMMY_W = facs_pkg::DUMMY_W;
   localparam int MODE_W  = facs_pkg::MODE_W;
   localparam int DEV_W   = facs_pkg::DEV_W;
   localparam int CNT_W   = facs_pkg::CNT_W;

   // Configuration registers.
   logic               octal_ff;
   logic [OPC_W-1:0]   rd_opc_ff;
   logic [DUMMY_W-1:0] rd_dummy_ff;
   logic [DEV_W-1:0]   dev_bytes_ff;

   // Sequencer state and working registers.
   facs_pkg::facs_state_type state_ff, state_in;
   logic              is_read_ff, is_read_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  off_ff, off_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_read_ff, rsp_read_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [OPC_W-1:0]   rsp_opc_ff, rsp_opc_in;
   logic [DUMMY_W-1:0] rsp_dummy_ff, rsp_dummy_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [OFF_W-1:0]   rsp_off_ff, rsp_off_in;
   logic [MODE_W-1:0]  rsp_mode_ff, rsp_mode_in;

   facs_pkg::facs_cmd_type step_cmd;
   logic [LEN_W-1:0]  req_len;
   logic [LEN_W-1:0]  rem_after;
   logic [DEV_W-1:0]  dev_room;
   logic              out_free;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         octal_ff     <= 1'b0;
         rd_opc_ff    <= facs_pkg::OCTAL_READ_OPC_RST;
         rd_dummy_ff  <= facs_pkg::OCTAL_READ_DUMMY_RST;
         dev_bytes_ff <= facs_pkg::DEVICE_BYTES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            facs_pkg::CSR_OCTAL_MODE:   octal_ff     <= csr_wdata[0];
            facs_pkg::CSR_OCTAL_RD_OPC: rd_opc_ff    <= csr_wdata[OPC_W-1:0];
            facs_pkg::CSR_OCTAL_RD_DUM: rd_dummy_ff  <= csr_wdata[DUMMY_W-1:0];
            facs_pkg::CSR_DEVICE_BYTES: dev_bytes_ff <= csr_wdata[DEV_W-1:0];
            default: ;
         endcase
      end
   end

   // Shared step unit.
   facs_step #(
      .PAGE_SIZE (PAGE_SIZE)
   ) u_step (
      .octal   (octal_ff),
      .is_read (is_read_ff),
      .addr    (addr_ff),
      .rem     (rem_ff),
      .cmd     (step_cmd)
   );

   // Requested length saturated to the largest request.
   assign req_len = (req_tdata[39:27] > LEN_W'(MAX_REQUEST)) ?
                    LEN_W'(MAX_REQUEST) : req_tdata[39:27];
   assign dev_room  = dev_bytes_ff - {1'b0, addr_ff};
   assign rem_after = rem_ff - step_cmd.used;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Next state and next values of the working and output registers.
   always_comb begin
      state_in     = state_ff;
      is_read_in   = is_read_ff;
      addr_in      = addr_ff;
      rem_in       = rem_ff;
      off_in       = off_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_read_in  = rsp_read_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_opc_in   = rsp_opc_ff;
      rsp_dummy_in = rsp_dummy_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_mode_in  = rsp_mode_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         facs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               is_read_in = req_tuser;
               addr_in    = req_tdata[ADDR_W-1:0];
               rem_in     = req_len;
               off_in     = '0;
               count_in   = '0;
               state_in   = facs_pkg::ST_CLIP;
            end
         end
         // Drop empty requests and reads past the end; clip the rest of the reads.
         facs_pkg::ST_CLIP: begin
            if (rem_ff == '0) begin
               state_in = facs_pkg::ST_IDLE;
            end else if (is_read_ff && ({1'b0, addr_ff} >= dev_bytes_ff)) begin
               state_in = facs_pkg::ST_IDLE;
            end else begin
               if (is_read_ff && ({{(DEV_W-LEN_W){1'b0}}, rem_ff} > dev_room)) begin
                  rem_in = dev_room[LEN_W-1:0];
               end
               state_in = facs_pkg::ST_RUN;
            end
         end
         // One command per cycle while the output register can take it.
         facs_pkg::ST_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_read_in  = is_read_ff;
               rsp_addr_in  = step_cmd.addr;
               rsp_len_in   = step_cmd.len;
               rsp_off_in   = off_ff[OFF_W-1:0];
               rsp_mode_in  = step_cmd.mode;
               rsp_last_in  = (rem_after == '0) ||
                              (count_ff == CNT_W'(facs_pkg::MAX_RESULTS - 1));
               if (is_read_ff) begin
                  rsp_opc_in   = octal_ff ? rd_opc_ff : facs_pkg::OPC_READ_SINGLE;
                  rsp_dummy_in = octal_ff ? rd_dummy_ff : facs_pkg::DUMMY_READ_SINGLE;
               end else begin
                  rsp_opc_in   = octal_ff ? facs_pkg::OPC_PROG_OCTAL :
                                            facs_pkg::OPC_PROG_SINGLE;
                  rsp_dummy_in = facs_pkg::DUMMY_PROG;
               end
               addr_in  = addr_ff + ADDR_W'(step_cmd.used);
               off_in   = off_ff + step_cmd.used;
               rem_in   = rem_after;
               count_in = count_ff + CNT_W'(1);
               if (rsp_last_in) begin
                  state_in = facs_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = facs_pkg::ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= facs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      is_read_ff   <= is_read_in;
      addr_ff      <= addr_in;
      rem_ff       <= rem_in;
      off_ff       <= off_in;
      count_ff     <= count_in;
      rsp_read_ff  <= rsp_read_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_opc_ff   <= rsp_opc_in;
      rsp_dummy_ff <= rsp_dummy_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_mode_ff  <= rsp_mode_in;
   end

   // Output ports.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_read_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_mode_ff, rsp_off_ff, rsp_len_ff, rsp_addr_ff,
                        rsp_dummy_ff, rsp_opc_ff};

   // A running request always has bytes left to cover.
   `FACS_ASSERT_NOW(a_run_has_bytes, clock, reset,
      state_ff == facs_pkg::ST_RUN, rem_ff != '0)
   // In octal mode every command is aligned to even address and length.
   `FACS_ASSERT_NOW(a_octal_even, clock, reset,
      rsp_valid_ff && octal_ff, !rsp_addr_ff[0] && !rsp_len_ff[0])
   // A pair command always moves exactly two bytes.
   `FACS_ASSERT_NOW(a_pair_len, clock, reset,
      rsp_valid_ff && (rsp_mode_ff != facs_pkg::PAIR_NONE), rsp_len_ff == LEN_W'(2))
   // An accepted request goes to length clipping next.
   `FACS_ASSERT_NEXT(a_accept_clip, clock, reset,
      req_tvalid && req_tready, state_ff == facs_pkg::ST_CLIP)

endmodule

`default_nettype wire

/* hw/rtl/facs_step.sv */
// Step unit: forms the next flash command from the current address and bytes left.
`default_nettype none

module facs_step #(
   parameter int PAGE_SIZE = facs_pkg::PAGE_SIZE_DEF
) (
   input  wire logic                        octal,
   input  wire logic                        is_read,
   input  wire logic [facs_pkg::ADDR_W-1:0] addr,
   input  wire logic [facs_pkg::LEN_W-1:0]  rem,
   output facs_pkg::facs_cmd_type           cmd
);

   localparam int PAGE_BITS = $clog2(PAGE_SIZE);

   logic [facs_pkg::LEN_W-1:0] page_room;
   logic [facs_pkg::LEN_W-1:0] chunk;

   // Bytes up to the end of the span: the page end for programs, all that is left for reads.
   always_comb begin
      page_room = facs_pkg::LEN_W'(PAGE_SIZE) -
                  facs_pkg::LEN_W'(addr[PAGE_BITS-1:0]);
      if (is_read || (page_room > rem)) begin
         chunk = rem;
      end else begin
         chunk = page_room;
      end
   end

   // Octal mode splits a span into an odd head pair, an even bulk and an odd tail pair.
   always_comb begin
      cmd.addr = addr;
      cmd.len  = chunk;
      cmd.mode = facs_pkg::PAIR_NONE;
      cmd.used = chunk;
      if (octal) begin
         if (addr[0]) begin
            cmd.addr = addr - facs_pkg::ADDR_W'(1);
            cmd.len  = facs_pkg::LEN_W'(2);
            cmd.mode = facs_pkg::PAIR_SECOND;
            cmd.used = facs_pkg::LEN_W'(1);
         end else if (chunk >= facs_pkg::LEN_W'(2)) begin
            cmd.len  = {chunk[facs_pkg::LEN_W-1:1], 1'b0};
            cmd.used = {chunk[facs_pkg::LEN_W-1:1], 1'b0};
         end else begin
            cmd.len  = facs_pkg::LEN_W'(2);
            cmd.mode = facs_pkg::PAIR_FIRST;
            cmd.used = facs_pkg::LEN_W'(1);
         end
      end
   end

endmodule

`default_nettype wire
